// File: hdl/ehc_pkg.sv
package ehc_pkg;

    localparam int MAX_INTERFACES = 4;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 48;

    localparam logic [6:0]  POS_MAX  = 7'd127;

    localparam logic [15:0] ET_IPV4  = 16'h0800;
    localparam logic [15:0] ET_ARP   = 16'h0806;
    localparam logic [15:0] ET_RARP  = 16'h8035;
    localparam logic [7:0]  PR_ICMP  = 8'h01;
    localparam logic [7:0]  PR_TCP   = 8'h06;
    localparam logic [7:0]  PR_UDP   = 8'h11;
    localparam logic [7:0]  IHL_MASK = 8'h0f;

    localparam logic [15:0] OP_ARP_REQ   = 16'd1;
    localparam logic [15:0] OP_ARP_REPLY = 16'd2;
    localparam logic [15:0] OP_RARP_REQ  = 16'd3;
    localparam logic [15:0] OP_RARP_REP  = 16'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IF_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAC_BASE = 3'd1;

    typedef enum logic [2:0] {
        CLS_NONE       = 3'd0,
        CLS_ICMP       = 3'd1,
        CLS_TCP        = 3'd2,
        CLS_UDP        = 3'd3,
        CLS_ARP_REQ    = 3'd4,
        CLS_ARP_REPLY  = 3'd5,
        CLS_RARP_REQ   = 3'd6,
        CLS_RARP_REPLY = 3'd7
    } t_pkt_class;

    // everything captured from one frame, handed from front to back
    typedef struct packed {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [15:0] ethertype;
        logic [3:0]  ihl;
        logic [7:0]  protocol;
        logic [15:0] arp_op;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [31:0] ports;
        logic [7:0]  len;
    } t_frame_rec;

    typedef struct packed {
        logic        iface_matched;
        logic [1:0]  iface_index;
        logic [2:0]  packet_class;
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic        header_short;
    } t_result;

endpackage

// File: hdl/ehc_front.sv
module ehc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_full,
    input  logic [7:0]          i_frame_byte,
    input  logic                i_first_of_frame,
    input  logic                i_last_of_frame,
    output logic                o_stall,
    output logic                o_push,
    output ehc_pkg::t_frame_rec o_rec
);
    import ehc_pkg::*;

    logic [6:0]  r_pos,   e_pos,   n_pos;
    logic [47:0] r_dmac,  e_dmac,  n_dmac;
    logic [47:0] r_smac,  e_smac,  n_smac;
    logic [15:0] r_et,    e_et,    n_et;
    logic [3:0]  r_ihl,   e_ihl,   n_ihl;
    logic [7:0]  r_proto, e_proto, n_proto;
    logic [15:0] r_op,    e_op,    n_op;
    logic [31:0] r_sip,   e_sip,   n_sip;
    logic [31:0] r_dip,   e_dip,   n_dip;
    logic [31:0] r_ports, e_ports, n_ports;
    logic [7:0]  pos8;
    logic [7:0]  port_start;
    logic        is_ip, is_arp, in_body, accept;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept && i_last_of_frame;

    always_comb begin
        // a first mark drops whatever the previous frame left
        e_pos   = i_first_of_frame ? '0 : r_pos;
        e_dmac  = i_first_of_frame ? '0 : r_dmac;
        e_smac  = i_first_of_frame ? '0 : r_smac;
        e_et    = i_first_of_frame ? '0 : r_et;
        e_ihl   = i_first_of_frame ? '0 : r_ihl;
        e_proto = i_first_of_frame ? '0 : r_proto;
        e_op    = i_first_of_frame ? '0 : r_op;
        e_sip   = i_first_of_frame ? '0 : r_sip;
        e_dip   = i_first_of_frame ? '0 : r_dip;
        e_ports = i_first_of_frame ? '0 : r_ports;

        n_dmac  = e_dmac;
        n_smac  = e_smac;
        n_et    = e_et;
        n_ihl   = e_ihl;
        n_proto = e_proto;
        n_op    = e_op;
        n_sip   = e_sip;
        n_dip   = e_dip;
        n_ports = e_ports;

        pos8    = {1'b0, e_pos};
        is_ip   = (e_et == ET_IPV4);
        is_arp  = (e_et == ET_ARP) || (e_et == ET_RARP);
        in_body = (e_pos >= 7'd14) && (e_pos < POS_MAX);

        if (e_pos < 7'd6) begin
            n_dmac = {e_dmac[39:0], i_frame_byte};
        end else if (e_pos < 7'd12) begin
            n_smac = {e_smac[39:0], i_frame_byte};
        end else if (e_pos < 7'd14) begin
            n_et = {e_et[7:0], i_frame_byte};
        end

        if (in_body && is_ip && (e_pos == 7'd14)) begin
            n_ihl = 4'(i_frame_byte & IHL_MASK);
        end
        // ports sit right after the IHL-sized header, even for small IHL
        port_start = 8'd14 + {2'b00, n_ihl, 2'b00};

        if (in_body && is_ip) begin
            if (pos8 >= port_start && pos8 < port_start + 8'd4) begin
                n_ports = {e_ports[23:0], i_frame_byte};
            end
            if (e_pos == 7'd23) begin
                n_proto = i_frame_byte;
            end
            if (e_pos >= 7'd26 && e_pos < 7'd30) begin
                n_sip = {e_sip[23:0], i_frame_byte};
            end
            if (e_pos >= 7'd30 && e_pos < 7'd34) begin
                n_dip = {e_dip[23:0], i_frame_byte};
            end
        end
        if (in_body && is_arp) begin
            if (e_pos == 7'd20 || e_pos == 7'd21) begin
                n_op = {e_op[7:0], i_frame_byte};
            end
            if (e_pos >= 7'd28 && e_pos < 7'd32) begin
                n_sip = {e_sip[23:0], i_frame_byte};
            end
            if (e_pos >= 7'd38 && e_pos < 7'd42) begin
                n_dip = {e_dip[23:0], i_frame_byte};
            end
        end

        n_pos = (e_pos < POS_MAX) ? e_pos + 7'd1 : e_pos;
    end

    always_comb begin
        o_rec.dest_mac   = n_dmac;
        o_rec.source_mac = n_smac;
        o_rec.ethertype  = n_et;
        o_rec.ihl        = n_ihl;
        o_rec.protocol   = n_proto;
        o_rec.arp_op     = n_op;
        o_rec.source_ip  = n_sip;
        o_rec.dest_ip    = n_dip;
        o_rec.ports      = n_ports;
        o_rec.len        = pos8 + 8'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_pos   <= '0;
            r_dmac  <= '0;
            r_smac  <= '0;
            r_et    <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_op    <= '0;
            r_sip   <= '0;
            r_dip   <= '0;
            r_ports <= '0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_dmac  <= n_dmac;
            r_smac  <= n_smac;
            r_et    <= n_et;
            r_ihl   <= n_ihl;
            r_proto <= n_proto;
            r_op    <= n_op;
            r_sip   <= n_sip;
            r_dip   <= n_dip;
            r_ports <= n_ports;
        end
    end

endmodule

// File: hdl/ehc_fifo.sv
module ehc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ehc_pkg::t_frame_rec i_rec,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_nonempty,
    output ehc_pkg::t_frame_rec o_rec
);
    import ehc_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_frame_rec       r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_rec      = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_nonempty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

// File: hdl/ehc_back.sv
module ehc_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    input  logic [ehc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [ehc_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                 i_rec_valid,
    input  ehc_pkg::t_frame_rec                  i_rec,
    input  logic                                 i_out_stall,
    output logic                                 o_pop,
    output logic                                 o_out_valid,
    output ehc_pkg::t_result                     o_result
);
    import ehc_pkg::*;

    logic [2:0]  r_if_count;
    logic [47:0] r_mac [MAX_INTERFACES];
    logic        r_valid;
    t_result     r_result, n_result;

    logic        is_ip, is_arp, has_ports, short_hdr, matched;
    logic [7:0]  need, need_ports;
    logic [2:0]  cnt_lim;
    logic [1:0]  idx;
    t_pkt_class  cls;

    assign o_pop       = i_rec_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_comb begin
        is_ip      = (i_rec.ethertype == ET_IPV4);
        is_arp     = (i_rec.ethertype == ET_ARP) || (i_rec.ethertype == ET_RARP);
        has_ports  = is_ip && ((i_rec.protocol == PR_TCP) || (i_rec.protocol == PR_UDP));
        need_ports = 8'd18 + {2'b00, i_rec.ihl, 2'b00};

        need = 8'd14;
        if (is_ip) begin
            need = 8'd34;
            if (has_ports && need_ports > 8'd34) begin
                need = need_ports;
            end
        end else if (is_arp) begin
            need = 8'd42;
        end
        short_hdr = (i_rec.len < need);

        cnt_lim = (r_if_count > 3'(MAX_INTERFACES)) ? 3'(MAX_INTERFACES) : r_if_count;
        matched = 1'b0;
        idx     = '0;
        // lowest index wins
        for (int i = 0; i < MAX_INTERFACES; i++) begin
            if (!matched && (3'(i) < cnt_lim) && (r_mac[i] == i_rec.dest_mac)) begin
                matched = 1'b1;
                idx     = 2'(i);
            end
        end

        cls = CLS_NONE;
        if (is_ip) begin
            if (i_rec.protocol == PR_ICMP) begin
                cls = CLS_ICMP;
            end else if (i_rec.protocol == PR_TCP) begin
                cls = CLS_TCP;
            end else if (i_rec.protocol == PR_UDP) begin
                cls = CLS_UDP;
            end
        end else if (i_rec.ethertype == ET_ARP) begin
            if (i_rec.arp_op == OP_ARP_REQ) begin
                cls = CLS_ARP_REQ;
            end else if (i_rec.arp_op == OP_ARP_REPLY) begin
                cls = CLS_ARP_REPLY;
            end
        end else if (i_rec.ethertype == ET_RARP) begin
            if (i_rec.arp_op == OP_RARP_REQ) begin
                cls = CLS_RARP_REQ;
            end else if (i_rec.arp_op == OP_RARP_REP) begin
                cls = CLS_RARP_REPLY;
            end
        end
        if (short_hdr) begin
            cls = CLS_NONE;
        end

        n_result = '0;
        if (matched) begin
            n_result.iface_matched = 1'b1;
            n_result.iface_index   = idx;
            n_result.packet_class  = cls;
            n_result.dest_mac      = i_rec.dest_mac;
            n_result.source_mac    = i_rec.source_mac;
            n_result.source_ip     = i_rec.source_ip;
            n_result.dest_ip       = i_rec.dest_ip;
            if (has_ports && !short_hdr) begin
                n_result.source_port = i_rec.ports[31:16];
                n_result.dest_port   = i_rec.ports[15:0];
            end
        end
        // reported even when no interface matched
        n_result.header_short = short_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_if_count <= '0;
            for (int i = 0; i < MAX_INTERFACES; i++) begin
                r_mac[i] <= '0;
            end
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_IF_COUNT) begin
                r_if_count <= i_cfg_data[2:0];
            end
            for (int i = 0; i < MAX_INTERFACES; i++) begin
                if (i_cfg_index == CFG_MAC_BASE + CFG_IDX_W'(i)) begin
                    r_mac[i] <= i_cfg_data[47:0];
                end
            end
        end
    end

endmodule

// File: hdl/ethernet_header_classifier_unit.sv
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_stall      frame_byte, first/last_of_frame
// output    out        o_out_valid / i_out_stall    classification result
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One frame byte is taken every cycle while o_in_stall is low; a frame's result is
// pushed into the queue with its last byte, then classified into the output register.
// A two-entry queue sits between capture and classification; the input stalls
// only when that queue is full, i.e. while the output has been held back.
// Synchronous active-low reset clears the frame state, queue and config.
// Configuration is always ready and applies on the transfer edge.
module ethernet_header_classifier_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [7:0]                     i_frame_byte,
    input  logic                           i_first_of_frame,
    input  logic                           i_last_of_frame,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_iface_matched,
    output logic [1:0]                     o_iface_index,
    output logic [2:0]                     o_packet_class,
    output logic [47:0]                    o_dest_mac,
    output logic [47:0]                    o_source_mac,
    output logic [31:0]                    o_source_ip,
    output logic [31:0]                    o_dest_ip,
    output logic [15:0]                    o_source_port,
    output logic [15:0]                    o_dest_port,
    output logic                           o_header_short,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ehc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ehc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ehc_pkg::*;

    t_frame_rec push_rec, head_rec;
    t_result    result;
    logic       push, pop, q_full, q_nonempty;

    assign o_cfg_ready = 1'b1;

    ehc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .i_full           (q_full),
        .i_frame_byte     (i_frame_byte),
        .i_first_of_frame (i_first_of_frame),
        .i_last_of_frame  (i_last_of_frame),
        .o_stall          (o_in_stall),
        .o_push           (push),
        .o_rec            (push_rec)
    );

    ehc_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_rec      (push_rec),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_rec      (head_rec)
    );

    ehc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rec_valid (q_nonempty),
        .i_rec       (head_rec),
        .i_out_stall (i_out_stall),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    assign o_iface_matched = result.iface_matched;
    assign o_iface_index   = result.iface_index;
    assign o_packet_class  = result.packet_class;
    assign o_dest_mac      = result.dest_mac;
    assign o_source_mac    = result.source_mac;
    assign o_source_ip     = result.source_ip;
    assign o_dest_ip       = result.dest_ip;
    assign o_source_port   = result.source_port;
    assign o_dest_port     = result.dest_port;
    assign o_header_short  = result.header_short;

endmodule
